FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define FDPCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdpcm assertion failed");

// next-cycle implication, checked while out of reset
`define FDPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdpcm assertion failed");

`endif

FILE: hw/rtl/fdpcm_pkg.sv
`timescale 1ns / 1ps

package fdpcm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int FRAME_W_W    = 13;
    localparam int FRAME_H_W    = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int FDPCM_MAX_WIDTH = 4096;

    localparam logic [FRAME_W_W-1:0] FRAME_W_RESET = FRAME_W_W'(1024);
    localparam logic [FRAME_H_W-1:0] FRAME_H_RESET = FRAME_H_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

    typedef enum logic {
        DIR_FORWARD = 1'b0,
        DIR_INVERSE = 1'b1
    } t_direction;

endpackage

FILE: hw/rtl/fdpcm_line_mem.sv
`timescale 1ns / 1ps

module fdpcm_line_mem
    import fdpcm_pkg::*;
#(
    parameter int DEPTH = FDPCM_MAX_WIDTH,
    parameter int AW    = $clog2(FDPCM_MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [SAMPLE_W-1:0] o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/frame_dpcm_transform_top.sv
`timescale 1ns / 1ps
// a sample is registered in stage 1 and then in the output register before its result transaction
// throughput: one sample per cycle, the line store takes at most one read and one write each cycle
// a held result stalls the input only when both pipeline stages are full
// reset (synchronous, active low): clears position counters, left value, pipeline valids
// and restores direction forward, width 1024, height 1024; the line store is not cleared

`include "assert_macros.svh"

module frame_dpcm_transform_top
    import fdpcm_pkg::*;
#(
    parameter int MAX_WIDTH = FDPCM_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SAMPLE_W-1:0]   o_value,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > FRAME_W_W) ? CW + 1 : FRAME_W_W;
    localparam int RW = FRAME_H_W + 1;

    // configuration
    t_direction           r_direction;
    logic [FRAME_W_W-1:0] r_frame_width;
    logic [FRAME_H_W-1:0] r_frame_height;

    // position
    logic [CW-1:0]        r_col;
    logic [FRAME_H_W-1:0] r_row;
    logic [SAMPLE_W-1:0]  r_left;

    // stage 1
    logic                 r_s1_valid;
    logic [SAMPLE_W-1:0]  r_s1_sample;
    logic [CW-1:0]        r_s1_col;
    logic                 r_s1_top;
    logic                 r_s1_first;
    logic                 r_s1_row_end;
    logic                 r_s1_frame_end;
    logic                 r_s1_fwd;
    logic [SAMPLE_W-1:0]  r_fwd_data;

    // output register
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_value;
    logic                 r_out_row_end;
    logic                 r_out_frame_end;

    logic                 in_acc;
    logic                 s1_adv;
    logic [EW-1:0]        col_inc;
    logic [RW-1:0]        row_inc;
    logic                 row_end_c;
    logic                 frame_end_c;
    logic [SAMPLE_W-1:0]  rd_data;
    logic [SAMPLE_W-1:0]  pred;
    logic [SAMPLE_W-1:0]  s1_res;
    logic [SAMPLE_W-1:0]  s1_wdata;
    logic                 pos_origin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= DIR_FORWARD;
            r_frame_width  <= FRAME_W_RESET;
            r_frame_height <= FRAME_H_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIRECTION:    r_direction    <= t_direction'(i_cfg_data[0]);
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_W_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_H_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // width zero acts as one, width above the store depth saturates
    assign col_inc     = EW'(r_col) + EW'(1);
    assign row_inc     = RW'(r_row) + RW'(1);
    assign row_end_c   = (col_inc >= EW'(r_frame_width)) || (r_col == CW'(MAX_WIDTH - 1));
    assign frame_end_c = row_end_c && (row_inc >= RW'(r_frame_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (row_end_c) begin
                r_col <= '0;
                r_row <= frame_end_c ? '0 : row_inc[FRAME_H_W-1:0];
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_s1_fwd   <= s1_adv && (r_s1_col == r_col);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample    <= i_sample;
            r_s1_col       <= r_col;
            r_s1_top       <= (r_row == '0);
            r_s1_first     <= (r_col == '0);
            r_s1_row_end   <= row_end_c;
            r_s1_frame_end <= frame_end_c;
            r_fwd_data     <= s1_wdata;
        end
    end

    fdpcm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (s1_wdata)
    );

    always_comb begin
        if (r_s1_top) begin
            pred = r_s1_first ? '0 : r_left;
        end else if (r_s1_fwd) begin
            pred = r_fwd_data;
        end else begin
            pred = rd_data;
        end
    end

    assign s1_res   = (r_direction == DIR_INVERSE) ? (r_s1_sample + pred)
                                                   : (r_s1_sample - pred);
    assign s1_wdata = (r_direction == DIR_INVERSE) ? s1_res : r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_adv) begin
            r_left <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value     <= s1_res;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    assign pos_origin = (r_col == '0) && (r_row == '0);

    `FDPCM_ASSERT_NOW(a_frame_end_row_end, i_clk, i_rst_n, o_valid && o_frame_end, o_row_end)
    `FDPCM_ASSERT_NOW(a_fwd_needs_s1, i_clk, i_rst_n, r_s1_fwd, r_s1_valid)
    `FDPCM_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, in_acc, !r_s1_valid || s1_adv)
    `FDPCM_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, in_acc && frame_end_c, pos_origin)

endmodule

FILE: tb/frame_dpcm_transform_top_test.sv
`timescale 1ns / 1ps

module frame_dpcm_transform_top_test;
    import fdpcm_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int LINE_DEPTH   = FDPCM_MAX_WIDTH;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int PRINT_CAP    = 20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                row_end;
        logic                frame_end;
    } t_pixel_out;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_DIRECTION;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [SAMPLE_W-1:0]   o_value;
    logic                  o_row_end;
    logic                  o_frame_end;

    // predictor state: line store, top-row left value, raster position, registers
    logic [SAMPLE_W-1:0]  line_mem [LINE_DEPTH];
    bit                   line_written [LINE_DEPTH];
    logic [SAMPLE_W-1:0]  prev_top   = '0;
    int unsigned          pos_col    = 0;
    int unsigned          pos_row    = 0;
    t_direction           cur_dir    = DIR_FORWARD;
    logic [FRAME_W_W-1:0] cur_width  = FRAME_W_RESET;
    logic [FRAME_H_W-1:0] cur_height = FRAME_H_RESET;

    logic [SAMPLE_W-1:0] sample_q [$];
    t_pixel_out          expected_q [$];
    logic [SAMPLE_W-1:0] last_sample = '0;

    int idle_pct         = 32;
    int error_count      = 0;
    int samples_accepted = 0;
    int results_checked  = 0;
    int frames_done      = 0;
    int reg_writes       = 0;
    int random_sent      = 0;
    int stall_cycles     = 0;

    frame_dpcm_transform_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned eff_width(logic [FRAME_W_W-1:0] wr);
        if (wr == 0) return 1;
        if (wr > LINE_DEPTH) return LINE_DEPTH;
        return wr;
    endfunction

    function automatic t_pixel_out dpcm_step(logic [SAMPLE_W-1:0] x);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [SAMPLE_W-1:0] pred;
        t_pixel_out res;
        w = eff_width(cur_width);
        h = (cur_height == 0) ? 1 : cur_height;
        c = (pos_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : pos_col;
        r = pos_row;
        if (r == 0) begin
            pred = (c == 0) ? '0 : prev_top;
        end else begin
            pred = line_mem[c];
        end
        if (cur_dir == DIR_FORWARD) begin
            res.value = x - pred;
            line_mem[c] = x;
        end else begin
            res.value = x + pred;
            line_mem[c] = res.value;
        end
        prev_top = line_mem[c];
        line_written[c] = 1'b1;
        res.row_end = (c + 1 >= w);
        res.frame_end = res.row_end && (r + 1 >= h);
        if (res.row_end) begin
            pos_col = 0;
            pos_row = res.frame_end ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            pos_col = c + 1;
        end
        return res;
    endfunction

    // a new width must not make the rest of this frame read a line entry never written
    function automatic bit width_safe(logic [FRAME_W_W-1:0] wr);
        int unsigned w;
        int unsigned c;
        w = eff_width(wr);
        if (pos_row == 0) return 1'b1;
        c = (pos_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : pos_col;
        do begin
            if (!line_written[c]) return 1'b0;
            c++;
        end while (c < w);
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample();
        case ($urandom_range(9))
            0: last_sample = 16'h0000;
            1: last_sample = 16'hFFFF;
            2: last_sample = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            3, 4, 5: last_sample = last_sample + 16'($urandom_range(6)) - 16'd3;
            default: last_sample = 16'($urandom);
        endcase
        return last_sample;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at result %0d: %s", results_checked, msg);
        end
        error_count++;
    endtask

    task automatic push_random(input int unsigned n);
        repeat (n) sample_q.push_back(next_sample());
    endtask

    // returns at a falling edge once every sample is accepted and every result checked
    task automatic drain();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_valid || expected_q.size() != 0);
    endtask

    // call at a rising edge; leaves valid high for a following write
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DIRECTION:    cur_dir    = t_direction'(data[0]);
            CFG_FRAME_WIDTH:  cur_width  = data[FRAME_W_W-1:0];
            CFG_FRAME_HEIGHT: cur_height = data[FRAME_H_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic close_cfg();
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // cut the frame short so a wide row can start from a clean position
    task automatic goto_frame_start();
        int unsigned w;
        int unsigned c;
        if (pos_col == 0 && pos_row == 0) return;
        @(posedge i_clk);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        close_cfg();
        w = eff_width(cur_width);
        c = (pos_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : pos_col;
        push_random((c + 1 >= w) ? 1 : w - c);
        drain();
    endtask

    always @(posedge i_clk) begin : sample_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.push_back(dpcm_step(i_sample));
                samples_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid  <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_pixel_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    flag_error($sformatf("unexpected transaction, value %h", o_value));
                end else begin
                    want = expected_q.pop_front();
                    if (o_value !== want.value)
                        flag_error($sformatf("value %h, expected %h", o_value, want.value));
                    if (o_row_end !== want.row_end)
                        flag_error($sformatf("row_end %b, expected %b", o_row_end,
                                             want.row_end));
                    if (o_frame_end !== want.frame_end)
                        flag_error($sformatf("frame_end %b, expected %b", o_frame_end,
                                             want.frame_end));
                end
                if (o_frame_end === 1'b1) frames_done++;
                results_checked++;
            end
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_q.size());
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_direction           d;
        logic [CFG_DATA_W-1:0] wr;
        logic [CFG_DATA_W-1:0] hr;
        int unsigned           n;
        int unsigned           mask;
        int unsigned           phase;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, top row only
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h0001);
        drain();

        // width shrinks below the current column, then one full second row
        @(posedge i_clk);
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        close_cfg();
        sample_q.push_back(16'h0001);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'h1234);
        drain();

        // inverse with zero width and zero height
        @(posedge i_clk);
        write_reg(CFG_DIRECTION, DIR_INVERSE);
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        close_cfg();
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h8000);
        drain();

        // full height, then height and direction change past the new last row
        @(posedge i_clk);
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        close_cfg();
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8001);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h0001);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        drain();
        @(posedge i_clk);
        write_reg(CFG_DIRECTION, DIR_FORWARD);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        close_cfg();
        sample_q.push_back(16'h5555);
        sample_q.push_back(16'hAAAA);
        drain();

        // single column, inverse
        @(posedge i_clk);
        write_reg(CFG_DIRECTION, DIR_INVERSE);
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        close_cfg();
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'h0001);
        sample_q.push_back(16'h8000);
        drain();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mask = (phase == 0) ? 7 : $urandom_range(1, 7);
            d = $urandom_range(1) ? DIR_INVERSE : DIR_FORWARD;
            case ($urandom_range(9))
                0: wr = 16'd0;
                1: wr = 16'($urandom_range(17, 64));
                default: wr = 16'($urandom_range(1, 9));
            endcase
            case ($urandom_range(9))
                0: hr = 16'd0;
                1: hr = 16'hFFFF;
                default: hr = 16'($urandom_range(1, 5));
            endcase
            if (!width_safe(wr[FRAME_W_W-1:0])) wr = 16'(cur_width);
            @(posedge i_clk);
            if (mask[0]) write_reg(CFG_DIRECTION, d);
            if (mask[1]) write_reg(CFG_FRAME_WIDTH, wr);
            if (mask[2]) write_reg(CFG_FRAME_HEIGHT, hr);
            close_cfg();
            idle_pct = (phase == 0) ? 0 : 32;
            n = (phase == 0) ? 300 : $urandom_range(8, 90);
            if (phase == 1 || $urandom_range(3) == 0) begin
                // sender holds off until the pipeline is empty
                push_random(n / 2);
                drain();
                push_random(n - n / 2);
            end else begin
                push_random(n);
            end
            random_sent += n;
            drain();
            phase++;
        end
        idle_pct = 32;

        // saturated and exact maximum width, each top row cut short by a width of one
        goto_frame_start();
        @(posedge i_clk);
        write_reg(CFG_DIRECTION, DIR_FORWARD);
        write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        close_cfg();
        push_random(64);
        drain();
        @(posedge i_clk);
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        close_cfg();
        push_random(1);
        drain();
        @(posedge i_clk);
        write_reg(CFG_DIRECTION, DIR_INVERSE);
        write_reg(CFG_FRAME_WIDTH, 16'(LINE_DEPTH));
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        close_cfg();
        push_random(40);
        drain();
        @(posedge i_clk);
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        close_cfg();
        push_random(1);
        drain();

        repeat (8) @(posedge i_clk);
        $display("covered %0d samples and %0d frames in both directions, %0d register writes",
                 samples_accepted, frames_done, reg_writes);
        $display("widths from zero to saturated, heights from zero to full, %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
